>>> src/mtc_pkg.sv
// shared types, constants and tables for the matrix transform composer
`timescale 1ns / 1ps
package mtc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_FRAC  = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
  localparam int CW           = 34;
  localparam int PROD_W       = 64;
  localparam int ACC_W        = PROD_W - FRAC_BITS + 2;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(32'sh26DD3B6A);
  localparam logic signed [CW-1:0] CORDIC_HALF =
    CW'(64'sd1 <<< (CORDIC_FRAC - FRAC_BITS - 1));
  localparam logic signed [31:0] FX_ONE = 32'(64'sd1 <<< FRAC_BITS);

  typedef enum logic [2:0] {
    CMD_LOAD_CUR = 3'd0,
    CMD_ROT_X    = 3'd1,
    CMD_ROT_Y    = 3'd2,
    CMD_ROT_Z    = 3'd3,
    CMD_SCALE    = 3'd4,
    CMD_XLATE    = 3'd5,
    CMD_LOAD_OP  = 3'd6,
    CMD_MULT     = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CORDIC = 4'b0010,
    ST_MAC    = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  // one multiply-accumulate beat into the shared unit
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [3:0] idx;
  } mac_ctl_t;

  // finished element out of the shared unit
  typedef struct packed {
    logic              vld;
    logic [3:0]        idx;
    logic              ovf;
    logic signed [31:0] val;
  } mac_res_t;

  // arctangent table in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sh20000000;
      5'd1:  v = 32'sh12E4051D;
      5'd2:  v = 32'sh09FB385B;
      5'd3:  v = 32'sh051111D4;
      5'd4:  v = 32'sh028B0D43;
      5'd5:  v = 32'sh0145D7E1;
      5'd6:  v = 32'sh00A2F61E;
      5'd7:  v = 32'sh00517C55;
      5'd8:  v = 32'sh0028BE53;
      5'd9:  v = 32'sh00145F2E;
      5'd10: v = 32'sh000A2F98;
      5'd11: v = 32'sh000517CC;
      5'd12: v = 32'sh00028BE6;
      5'd13: v = 32'sh000145F3;
      5'd14: v = 32'sh0000A2F9;
      5'd15: v = 32'sh0000517C;
      5'd16: v = 32'sh000028BE;
      5'd17: v = 32'sh0000145F;
      5'd18: v = 32'sh00000A2F;
      5'd19: v = 32'sh00000517;
      5'd20: v = 32'sh0000028B;
      5'd21: v = 32'sh00000145;
      5'd22: v = 32'sh000000A2;
      5'd23: v = 32'sh00000051;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

endpackage

>>> src/mtc_cordic.sv
// iterative rotation-mode cordic giving cosine and sine of a 16-bit angle
`timescale 1ns / 1ps
module mtc_cordic
  import mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] i_r, i_nxt;
  logic [1:0]        q_r, q_nxt;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0]   z_r, z_nxt;
  logic [15:0]          a_sum, r16;
  logic signed [CW-1:0] x_sh, y_sh, x_rnd, y_rnd;
  logic signed [31:0]   c_v, s_v;

  // quadrant split of the input angle
  assign a_sum = angle + 16'h2000;
  assign r16   = angle - {a_sum[15:14], 14'b0};

  // shared shifters for the current step
  assign x_sh = x_r >>> i_r;
  assign y_sh = y_r >>> i_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    i_nxt    = i_r;
    q_nxt    = q_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      run_nxt = 1'b1;
      i_nxt   = '0;
      q_nxt   = a_sum[15:14];
      x_nxt   = CORDIC_GAIN;
      y_nxt   = '0;
      z_nxt   = {r16, 16'b0};
    end else if (run_r) begin
      if (!z_r[31]) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - atan_turn(i_r);
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + atan_turn(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    i_r <= i_nxt;
    q_r <= q_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // round to the output format and rotate by the quadrant
  assign x_rnd = (x_r + CORDIC_HALF) >>> (CORDIC_FRAC - FRAC_BITS);
  assign y_rnd = (y_r + CORDIC_HALF) >>> (CORDIC_FRAC - FRAC_BITS);
  assign c_v   = x_rnd[31:0];
  assign s_v   = y_rnd[31:0];

  always_comb begin
    case (q_r)
      2'd0: begin cos_o = c_v;  sin_o = s_v;  end
      2'd1: begin cos_o = -s_v; sin_o = c_v;  end
      2'd2: begin cos_o = -c_v; sin_o = -s_v; end
      default: begin cos_o = s_v; sin_o = -c_v; end
    endcase
  end

  assign done = done_r;

endmodule

>>> src/mtc_mac.sv
// shared multiply-accumulate unit with truncation and saturation
`timescale 1ns / 1ps
module mtc_mac
  import mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mac_ctl_t           ctl,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output mac_res_t           res
);

  logic signed [PROD_W-1:0] prod_r;
  mac_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, term;
  logic signed [PROD_W-1:0] prod_sh;
  mac_res_t                 res_r, res_nxt;

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) ctl_r <= '0;
    else        ctl_r <= ctl;
    prod_r <= op_a * op_b;
  end

  // accumulate the truncated product
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign term    = ACC_W'(prod_sh);
  assign acc_nxt = (ctl_r.first ? ACC_W'(0) : acc_r) + term;

  // saturate on the last term of an element
  always_comb begin
    res_nxt     = '0;
    res_nxt.vld = ctl_r.vld && ctl_r.last;
    res_nxt.idx = ctl_r.idx;
    res_nxt.val = acc_nxt[31:0];
    if (acc_nxt > ACC_W'(32'sh7FFFFFFF)) begin
      res_nxt.val = 32'sh7FFFFFFF;
      res_nxt.ovf = 1'b1;
    end else if (acc_nxt < ACC_W'(-33'sd2147483648)) begin
      res_nxt.val = 32'sh80000000;
      res_nxt.ovf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_r <= '0;
    else        res_r <= res_nxt;
    if (ctl_r.vld) acc_r <= acc_nxt;
  end

  assign res = res_r;

endmodule

>>> src/matrix_transform_composer.sv
// top level: matrix store, command sequencer and row output
//
// Command interface: a command is taken on a clock edge with start high and
// busy low. Row loads (current or operand) are written at once and leave busy
// low, so another command may follow in the next cycle. Every other command
// raises busy and replaces the current matrix by T * current.
// Rotations first run the cordic: 16 steps, one per cycle, then hand cosine
// and sine over through a register. The product then runs through the one
// shared multiplier: 64 multiply-accumulate beats, one per cycle, then its
// multiply and result registers. The four result rows follow on consecutive
// cycles, each marked by out_valid for one cycle, row 0 first, out_last on
// row 3, out_overflow when any element of that row saturated. busy falls
// after the last row. The receiver cannot stall: rows are shown once and
// must be taken.
// Reset (rst_n low at a clock edge) sets the current matrix to identity and
// the sequencer to idle; the operand matrix holds no value until loaded.
`timescale 1ns / 1ps
module matrix_transform_composer
  import mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [15:0] in_angle,
  input  logic [1:0]         in_row_index,
  input  logic signed [31:0] in_val_a,
  input  logic signed [31:0] in_val_b,
  input  logic signed [31:0] in_val_c,
  input  logic signed [31:0] in_val_d,
  output logic               out_valid,
  output logic [1:0]         out_row,
  output logic signed [31:0] out_col_zero,
  output logic signed [31:0] out_col_one,
  output logic signed [31:0] out_col_two,
  output logic signed [31:0] out_col_three,
  output logic               out_overflow,
  output logic               out_last
);

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, in_cmd_e;
  logic signed [31:0] va_r, vb_r, vc_r, cs_r, sn_r;
  logic signed [31:0] cur_r [4][4];
  logic signed [31:0] op_r  [4][4];
  logic signed [31:0] res_r [4][4];
  logic [3:0]         rovf_r;
  logic [5:0]         idx_r, idx_nxt;
  logic [1:0]         row_r, row_nxt;
  logic               accept, cord_start, cord_done;
  logic signed [31:0] cord_c, cord_s, t_el;
  logic [1:0]         mj, mi, mk;
  mac_ctl_t           mctl;
  mac_res_t           mres;
  logic               mac_done;
  logic               issued_r, issued_nxt;

  assign in_cmd_e = cmd_t'(in_cmd);
  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);

  assign cord_start = accept && (in_cmd_e == CMD_ROT_X || in_cmd_e == CMD_ROT_Y ||
                                 in_cmd_e == CMD_ROT_Z);

  mtc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (in_angle),
    .done  (cord_done),
    .cos_o (cord_c),
    .sin_o (cord_s)
  );

  // beat index order is row j, column i, term k
  assign mj = idx_r[5:4];
  assign mi = idx_r[3:2];
  assign mk = idx_r[1:0];

  // transform element T[j][k]
  always_comb begin
    t_el = (mj == mk) ? FX_ONE : 32'sd0;
    case (cmd_r)
      CMD_ROT_X: begin
        if      (mj == 2'd1 && mk == 2'd1) t_el = cs_r;
        else if (mj == 2'd1 && mk == 2'd2) t_el = sn_r;
        else if (mj == 2'd2 && mk == 2'd1) t_el = -sn_r;
        else if (mj == 2'd2 && mk == 2'd2) t_el = cs_r;
      end
      CMD_ROT_Y: begin
        if      (mj == 2'd0 && mk == 2'd0) t_el = cs_r;
        else if (mj == 2'd0 && mk == 2'd2) t_el = -sn_r;
        else if (mj == 2'd2 && mk == 2'd0) t_el = sn_r;
        else if (mj == 2'd2 && mk == 2'd2) t_el = cs_r;
      end
      CMD_ROT_Z: begin
        if      (mj == 2'd0 && mk == 2'd0) t_el = cs_r;
        else if (mj == 2'd0 && mk == 2'd1) t_el = -sn_r;
        else if (mj == 2'd1 && mk == 2'd0) t_el = sn_r;
        else if (mj == 2'd1 && mk == 2'd1) t_el = cs_r;
      end
      CMD_SCALE: begin
        if      (mj == 2'd0 && mk == 2'd0) t_el = va_r;
        else if (mj == 2'd1 && mk == 2'd1) t_el = vb_r;
        else if (mj == 2'd2 && mk == 2'd2) t_el = vc_r;
      end
      CMD_XLATE: begin
        if      (mj == 2'd0 && mk == 2'd3) t_el = va_r;
        else if (mj == 2'd1 && mk == 2'd3) t_el = vb_r;
        else if (mj == 2'd2 && mk == 2'd3) t_el = vc_r;
      end
      CMD_MULT: t_el = op_r[mj][mk];
      default:  t_el = (mj == mk) ? FX_ONE : 32'sd0;
    endcase
  end

  // issue one beat per cycle in the mac state
  always_comb begin
    mctl       = '0;
    mctl.vld   = (state_r == ST_MAC) && !mac_done;
    mctl.first = (mk == 2'd0);
    mctl.last  = (mk == 2'd3);
    mctl.idx   = idx_r[5:2];
  end

  mtc_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mctl),
    .op_a (t_el),
    .op_b (cur_r[mk][mi]),
    .res  (mres)
  );

  // all 64 beats issued, only the pipeline is draining
  assign mac_done = issued_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    issued_nxt = issued_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt    = '0;
        row_nxt    = '0;
        issued_nxt = 1'b0;
        if (accept && in_cmd_e != CMD_LOAD_CUR && in_cmd_e != CMD_LOAD_OP)
          state_nxt = cord_start ? ST_CORDIC : ST_MAC;
      end
      ST_CORDIC: if (cord_done) state_nxt = ST_MAC;
      ST_MAC: begin
        if (!issued_r) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 6'd63) issued_nxt = 1'b1;
        end
        if (mres.vld && mres.idx == 4'd15) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        row_nxt = row_r + 1'b1;
        if (row_r == 2'd3) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
    idx_r <= idx_nxt;
    row_r <= row_nxt;
  end

  // command capture and cordic results
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd_e;
      va_r  <= in_val_a;
      vb_r  <= in_val_b;
      vc_r  <= in_val_c;
    end
    if (cord_done) begin
      cs_r <= cord_c;
      sn_r <= cord_s;
    end
  end

  // operand matrix row loads
  always_ff @(posedge clk) begin
    if (accept && in_cmd_e == CMD_LOAD_OP) begin
      op_r[in_row_index][0] <= in_val_a;
      op_r[in_row_index][1] <= in_val_b;
      op_r[in_row_index][2] <= in_val_c;
      op_r[in_row_index][3] <= in_val_d;
    end
  end

  // result buffer and per-row overflow flags
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) rovf_r <= '0;
    else if (mres.vld && mres.ovf) rovf_r[mres.idx[3:2]] <= 1'b1;
    if (mres.vld) res_r[mres.idx[3:2]][mres.idx[1:0]] <= mres.val;
  end

  // current matrix: identity at reset, row loads, copy back while emitting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++)
        for (int i = 0; i < 4; i++)
          cur_r[j][i] <= (i == j) ? FX_ONE : 32'sd0;
    end else if (accept && in_cmd_e == CMD_LOAD_CUR) begin
      cur_r[in_row_index][0] <= in_val_a;
      cur_r[in_row_index][1] <= in_val_b;
      cur_r[in_row_index][2] <= in_val_c;
      cur_r[in_row_index][3] <= in_val_d;
    end else if (state_r == ST_EMIT) begin
      for (int i = 0; i < 4; i++)
        cur_r[row_r][i] <= res_r[row_r][i];
    end
  end

  // row output beats
  assign out_valid     = (state_r == ST_EMIT);
  assign out_row       = row_r;
  assign out_col_zero  = res_r[row_r][0];
  assign out_col_one   = res_r[row_r][1];
  assign out_col_two   = res_r[row_r][2];
  assign out_col_three = res_r[row_r][3];
  assign out_overflow  = rovf_r[row_r];
  assign out_last      = (row_r == 2'd3);

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("row beat while idle");
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy) else $error("busy held after last row");
  a_emit_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_valid && out_row == $past(out_row) + 2'd1))
    else $error("rows not emitted back to back");

endmodule

>>> tb/tb_matrix_transform_composer.sv
// self-checking testbench for the matrix transform composer
`timescale 1ns / 1ps
module tb_matrix_transform_composer
  import mtc_pkg::*;
();

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] angle;
    logic [1:0]         row_index;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic signed [31:0] val_c;
    logic signed [31:0] val_d;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               ovf;
    logic               last;
  } row_beat_t;

  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_cmd;
  logic signed [15:0] in_angle;
  logic [1:0]         in_row_index;
  logic signed [31:0] in_val_a, in_val_b, in_val_c, in_val_d;
  logic               out_valid;
  logic [1:0]         out_row;
  logic signed [31:0] out_col_zero, out_col_one, out_col_two, out_col_three;
  logic               out_overflow;
  logic               out_last;

  matrix_transform_composer u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_angle(in_angle), .in_row_index(in_row_index),
    .in_val_a(in_val_a), .in_val_b(in_val_b), .in_val_c(in_val_c),
    .in_val_d(in_val_d), .out_valid(out_valid), .out_row(out_row),
    .out_col_zero(out_col_zero), .out_col_one(out_col_one),
    .out_col_two(out_col_two), .out_col_three(out_col_three),
    .out_overflow(out_overflow), .out_last(out_last)
  );

  cmd_beat_t          pending_cmds[$];
  row_beat_t          expected_rows[$];
  logic signed [31:0] cur_mat[4][4];
  logic signed [31:0] op_mat[4][4];
  int                 mismatch_count;
  int                 idle_count;
  bit                 idle_enable;
  int                 dog;

  // arctangent table, 2^-32 turn units
  function automatic logic signed [63:0] atan_entry(int i);
    logic signed [31:0] tbl[24] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
    return 64'(tbl[i]);
  endfunction

  // cordic sine and cosine with quadrant folding
  task automatic calc_sin_cos(input logic [15:0] ang, output logic signed [31:0] co,
                              output logic signed [31:0] si);
    logic [15:0]        quad_sum;
    logic [1:0]         quad;
    logic [15:0]        resid;
    logic signed [63:0] z, x, y, nx, half;
    logic signed [31:0] cc, ss;
    quad_sum = ang + 16'h2000;
    quad = quad_sum[15:14];
    resid = ang - {quad, 14'd0};
    z = 64'(signed'(resid)) * 65536;
    x = 64'sh26DD3B6A;
    y = 0;
    half = 64'sd1 <<< (CORDIC_FRAC - FRAC_BITS - 1);
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_entry(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_entry(i);
      end
      x = nx;
    end
    cc = 32'((x + half) >>> (CORDIC_FRAC - FRAC_BITS));
    ss = 32'((y + half) >>> (CORDIC_FRAC - FRAC_BITS));
    case (quad)
      2'd0: begin co = cc;  si = ss;  end
      2'd1: begin co = -ss; si = cc;  end
      2'd2: begin co = -cc; si = -ss; end
      default: begin co = ss; si = -cc; end
    endcase
  endtask

  // apply one command to the matrix copy and queue the rows it yields
  task automatic predict_transform(input cmd_beat_t b);
    logic signed [31:0]  t[4][4];
    logic signed [31:0]  nm[4][4];
    logic signed [31:0]  co, si;
    logic signed [127:0] acc;
    logic signed [63:0]  prod;
    bit                  ovf[4];
    row_beat_t           r;
    if (b.cmd == CMD_LOAD_CUR || b.cmd == CMD_LOAD_OP) begin
      if (b.cmd == CMD_LOAD_CUR) begin
        cur_mat[b.row_index] = '{b.val_a, b.val_b, b.val_c, b.val_d};
      end else begin
        op_mat[b.row_index] = '{b.val_a, b.val_b, b.val_c, b.val_d};
      end
      return;
    end
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++)
        t[j][i] = (i == j) ? FX_ONE : 32'sd0;
    co = 0;
    si = 0;
    if (b.cmd inside {CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z}) calc_sin_cos(b.angle, co, si);
    case (cmd_t'(b.cmd))
      CMD_ROT_X: begin t[1][1] = co; t[1][2] = si; t[2][1] = -si; t[2][2] = co; end
      CMD_ROT_Y: begin t[0][0] = co; t[0][2] = -si; t[2][0] = si; t[2][2] = co; end
      CMD_ROT_Z: begin t[0][0] = co; t[0][1] = -si; t[1][0] = si; t[1][1] = co; end
      CMD_SCALE: begin t[0][0] = b.val_a; t[1][1] = b.val_b; t[2][2] = b.val_c; end
      CMD_XLATE: begin t[0][3] = b.val_a; t[1][3] = b.val_b; t[2][3] = b.val_c; end
      default: t = op_mat;
    endcase
    for (int j = 0; j < 4; j++) begin
      ovf[j] = 0;
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = 64'(t[j][k]) * 64'(cur_mat[k][i]);
          acc = acc + 128'(prod >>> FRAC_BITS);
        end
        if (acc > 128'sh7FFFFFFF) begin
          nm[j][i] = 32'sh7FFFFFFF;
          ovf[j] = 1;
        end else if (acc < -128'sh80000000) begin
          nm[j][i] = 32'sh80000000;
          ovf[j] = 1;
        end else begin
          nm[j][i] = 32'(acc);
        end
      end
    end
    cur_mat = nm;
    for (int j = 0; j < 4; j++) begin
      r.row = 2'(j);
      r.c0 = nm[j][0];
      r.c1 = nm[j][1];
      r.c2 = nm[j][2];
      r.c3 = nm[j][3];
      r.ovf = ovf[j];
      r.last = (j == 3);
      expected_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic signed [31:0] rand_fx();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return 32'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic cmd_beat_t make_cmd(input logic [2:0] cmd, input logic [1:0] row);
    cmd_beat_t b;
    b.cmd = cmd;
    b.angle = 16'($urandom);
    b.row_index = row;
    b.val_a = rand_fx();
    b.val_b = rand_fx();
    b.val_c = rand_fx();
    b.val_d = rand_fx();
    return b;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // stimulus list
  initial begin
    cmd_beat_t b;
    rst_n = 0;
    mismatch_count = 0;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        cur_mat[j][i] = (i == j) ? FX_ONE : 32'sd0;
        op_mat[j][i] = 0;
      end
    // directed: special angles, extremes, every command
    for (int n = 0; n < 8; n++) begin
      b = make_cmd(CMD_ROT_X + 3'(n % 3), 0);
      b.angle = 16'(n * 16'h2000);
      pending_cmds.push_back(b);
    end
    b = make_cmd(CMD_ROT_Z, 0); b.angle = 16'sh7FFF; pending_cmds.push_back(b);
    b = make_cmd(CMD_ROT_Y, 0); b.angle = 16'sh8000; pending_cmds.push_back(b);
    b = make_cmd(CMD_SCALE, 0);
    b.val_a = 32'sh7FFFFFFF; b.val_b = 32'sh80000000; b.val_c = 32'sh00010000;
    pending_cmds.push_back(b);
    b = make_cmd(CMD_XLATE, 0);
    b.val_a = 32'sh80000000; b.val_b = 32'sh7FFFFFFF; b.val_c = 0;
    pending_cmds.push_back(b);
    for (int r = 0; r < 4; r++) begin
      b = make_cmd(CMD_LOAD_OP, 2'(r));
      b.val_a = (r == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      b.val_b = 32'hFFFFFFFF;
      pending_cmds.push_back(b);
    end
    pending_cmds.push_back(make_cmd(CMD_MULT, 0));
    for (int r = 0; r < 4; r++) pending_cmds.push_back(make_cmd(CMD_LOAD_CUR, 2'(r)));
    pending_cmds.push_back(make_cmd(CMD_ROT_X, 0));
    // random: mostly well-formed, operand fully loaded before any multiply
    for (int n = 0; n < 450; n++) begin
      b = make_cmd(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      if (b.cmd == CMD_LOAD_CUR && $urandom_range(0, 3) != 0) begin
        // keep values small most of the time so saturation stays occasional
        b.val_a = 32'(int'($urandom_range(0, 131072)) - 65536);
        b.val_b = 32'(int'($urandom_range(0, 131072)) - 65536);
      end
      if (b.cmd == CMD_SCALE && $urandom_range(0, 2) != 0) begin
        b.val_a = 32'(int'($urandom_range(0, 131072)) - 65536);
        b.val_b = 32'(int'($urandom_range(0, 131072)) - 65536);
        b.val_c = 32'(int'($urandom_range(0, 131072)) - 65536);
      end
      pending_cmds.push_back(b);
    end
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
  end

  // driver: random idle gaps except for a back-to-back stretch in the middle
  initial idle_count = 0;
  always @(posedge clk) begin
    cmd_beat_t nb;
    if (!rst_n) begin
      start <= 0;
      {in_cmd, in_angle, in_row_index, in_val_a, in_val_b, in_val_c, in_val_d} <= '0;
      idle_count <= 0;
    end else begin
      if (start && !busy) begin
        nb.cmd = in_cmd; nb.angle = in_angle; nb.row_index = in_row_index;
        nb.val_a = in_val_a; nb.val_b = in_val_b; nb.val_c = in_val_c; nb.val_d = in_val_d;
        predict_transform(nb);
        void'(pending_cmds.pop_front());
        idle_count <= idle_count + 1;
      end
      if (!(start && busy)) begin
        idle_enable = !(idle_count > 150 && idle_count < 260);
        if (pending_cmds.size() > 0 && !(idle_enable && $urandom_range(0, 99) < 17)) begin
          nb = pending_cmds[0];
          start <= 1;
          in_cmd <= nb.cmd; in_angle <= nb.angle; in_row_index <= nb.row_index;
          in_val_a <= nb.val_a; in_val_b <= nb.val_b;
          in_val_c <= nb.val_c; in_val_d <= nb.val_d;
        end else begin
          start <= 0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    row_beat_t w;
    if (rst_n && out_valid) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row", 32'(out_row), 0);
      end else begin
        w = expected_rows.pop_front();
        if (out_row !== w.row) report_mismatch("row", 32'(out_row), 32'(w.row));
        if (out_col_zero !== w.c0) report_mismatch("col0", out_col_zero, w.c0);
        if (out_col_one !== w.c1) report_mismatch("col1", out_col_one, w.c1);
        if (out_col_two !== w.c2) report_mismatch("col2", out_col_two, w.c2);
        if (out_col_three !== w.c3) report_mismatch("col3", out_col_three, w.c3);
        if (out_overflow !== w.ovf) report_mismatch("overflow", 32'(out_overflow), 32'(w.ovf));
        if (out_last !== w.last) report_mismatch("last", 32'(out_last), 32'(w.last));
      end
    end
  end

  // watchdog and end of run
  initial begin
    dog = 0;
    @(posedge rst_n);
    while (pending_cmds.size() > 0 || expected_rows.size() > 0 || start) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) dog = 0;
      else dog++;
      if (dog >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> matrix_transform_composer.f
src/mtc_pkg.sv
src/mtc_cordic.sv
src/mtc_mac.sv
src/matrix_transform_composer.sv
tb/tb_matrix_transform_composer.sv
